/* rtl/core/rsdp_scan_pkg.sv */
`default_nettype none

package rsdp_scan_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_STRUCT_LEN = 64;
    localparam int DEF_MIN_REGION_LEN = 1024;
    localparam int DEF_OFFSET_WIDTH   = 17;

    // Region length after reset
    localparam int REGION_LEN_RST = 1024;

    // Width of the reported length field
    localparam int TABLE_LEN_W = 7;

    // Signature bytes, "RSD PTR "
    localparam int SIG_LEN = 8;
    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'h52, 8'h53, 8'h44, 8'h20, 8'h50, 8'h54, 8'h52, 8'h20
    };

    // Controller states
    typedef enum logic [2:0] {
        ST_RUN,
        ST_SCAN,
        ST_FLUSH,
        ST_EMIT_HIT,
        ST_EMIT_MISS
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic shift;       // shift one byte into the window
        logic zero_fill;   // shifted byte is zero instead of input data
        logic rotate;      // rotate window by one, accumulate checksum
        logic scan_start;  // latch length, clear checksum and scan index
        logic flush_load;  // load end-of-region zero-fill count
        logic flush_dec;   // one zero-fill step done
        logic cnt_clear;   // start a new region
        logic load_hit;    // load a found result into the output register
        logic load_miss;   // load a not-found result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cand_ok;     // window head passes header checks
        logic scan_last;   // final rotation of a checksum scan
        logic sum_zero;    // checksum including this rotation is zero
        logic flush_done;  // no zero-fill steps left
        logic out_free;    // output register can take a result
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/rsdp_scan_ctrl.sv */
`default_nettype none

module rsdp_scan_ctrl
    import rsdp_scan_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    in_last,
    output logic         in_ready,
    input  wire status_t sts,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;    // window head not yet checked
    logic   sent_reg, sent_next;    // result of this region already given
    logic   flush_reg, flush_next;  // last byte of region taken
    logic   hit;

    assign hit = pend_reg && sts.cand_ok && !sent_reg;

    // State and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            pend_reg  <= 1'b0;
            sent_reg  <= 1'b0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            sent_reg  <= sent_next;
            flush_reg <= flush_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (hit)
                    state_next = ST_SCAN;
                else if (in_valid && in_last)
                    state_next = ST_FLUSH;
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    if (sts.sum_zero)
                        state_next = ST_EMIT_HIT;
                    else if (flush_reg)
                        state_next = ST_FLUSH;
                    else
                        state_next = ST_RUN;
                end
            end
            ST_FLUSH:
            begin
                if (sent_reg)
                    state_next = ST_RUN;
                else if (hit)
                    state_next = ST_SCAN;
                else if (sts.flush_done)
                    state_next = ST_EMIT_MISS;
            end
            ST_EMIT_HIT,
            ST_EMIT_MISS:
            begin
                if (sts.out_free)
                    state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    // Commands and flag updates
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        pend_next  = pend_reg;
        sent_next  = sent_reg;
        flush_next = flush_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (hit)
                begin
                    cmd.scan_start = 1'b1;
                end
                else
                begin
                    in_ready  = 1'b1;
                    pend_next = 1'b0;
                    if (in_valid)
                    begin
                        cmd.shift = 1'b1;
                        pend_next = 1'b1;
                        if (in_last)
                        begin
                            cmd.flush_load = 1'b1;
                            flush_next     = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rotate = 1'b1;
                if (sts.scan_last)
                    pend_next = 1'b0;
            end
            ST_FLUSH:
            begin
                if (sent_reg)
                begin
                    cmd.cnt_clear = 1'b1;
                    sent_next     = 1'b0;
                    flush_next    = 1'b0;
                    pend_next     = 1'b0;
                end
                else if (hit)
                begin
                    cmd.scan_start = 1'b1;
                end
                else if (!sts.flush_done)
                begin
                    cmd.shift     = 1'b1;
                    cmd.zero_fill = 1'b1;
                    cmd.flush_dec = 1'b1;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_EMIT_HIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_hit = 1'b1;
                    sent_next    = 1'b1;
                    if (flush_reg)
                    begin
                        cmd.cnt_clear = 1'b1;
                        sent_next     = 1'b0;
                        flush_next    = 1'b0;
                        pend_next     = 1'b0;
                    end
                end
            end
            ST_EMIT_MISS:
            begin
                if (sts.out_free)
                begin
                    cmd.load_miss = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    sent_next     = 1'b0;
                    flush_next    = 1'b0;
                    pend_next     = 1'b0;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/rsdp_scan_dp.sv */
`default_nettype none

module rsdp_scan_dp
    import rsdp_scan_pkg::*;
#(
    parameter int MAX_STRUCT_LEN = DEF_MAX_STRUCT_LEN,
    parameter int MIN_REGION_LEN = DEF_MIN_REGION_LEN,
    parameter int OFFSET_WIDTH   = DEF_OFFSET_WIDTH,
    parameter int TDATA_W        = ((OFFSET_WIDTH + TABLE_LEN_W + 7) / 8) * 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmd_t                    cmd,
    output status_t                      sts,
    input  wire logic [7:0]              in_data,
    input  wire logic                    cfg_we,
    input  wire logic [OFFSET_WIDTH-1:0] cfg_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [TDATA_W-1:0]           out_data,
    output logic                         out_found
);

    localparam int CNT_W = OFFSET_WIDTH + 1;
    localparam int IDX_W = $clog2(MAX_STRUCT_LEN);
    localparam int LEN_W = $clog2(MAX_STRUCT_LEN + 1);

    logic [7:0]              win_reg [MAX_STRUCT_LEN];
    logic [7:0]              win_next [MAX_STRUCT_LEN];
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        newest_reg, newest_next;
    logic [IDX_W-1:0]        flush_cnt_reg, flush_cnt_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [7:0]              sum_reg, sum_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [OFFSET_WIDTH-1:0] region_len_reg, region_len_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_found_reg, out_found_next;
    logic [OFFSET_WIDTH-1:0] out_off_reg, out_off_next;
    logic [TABLE_LEN_W-1:0]  out_len_reg, out_len_next;

    logic [31:0]             len_field;
    logic [CNT_W-1:0]        head_off;
    logic                    sig_ok;
    logic                    hdr_ok;
    logic [7:0]              add_byte;

    // Header checks on the window head (offset p at index 0)
    always_comb
    begin
        sig_ok = 1'b1;
        for (int k = 0; k < SIG_LEN; k++)
            sig_ok = sig_ok && (win_reg[k] == SIG_BYTES[k]);
    end

    assign len_field = {win_reg[23], win_reg[22], win_reg[21], win_reg[20]};
    assign head_off  = newest_reg - CNT_W'(MAX_STRUCT_LEN - 1);

    assign hdr_ok = sig_ok
                 && (win_reg[15] != 8'd0)
                 && (len_field != 32'd0)
                 && (len_field <= 32'(MAX_STRUCT_LEN));

    assign sts.cand_ok = hdr_ok
                      && (newest_reg >= CNT_W'(MAX_STRUCT_LEN - 1))
                      && (head_off <= {1'b0, region_len_reg})
                      && (32'(region_len_reg) >= 32'(MIN_REGION_LEN));

    // Checksum accumulation during window rotation
    assign add_byte  = (LEN_W'(idx_reg) < len_reg) ? win_reg[0] : 8'd0;
    assign sum_next  = cmd.scan_start ? 8'd0 : (cmd.rotate ? sum_reg + add_byte : sum_reg);
    assign sts.sum_zero   = ((sum_reg + add_byte) == 8'd0);
    assign sts.scan_last  = (idx_reg == IDX_W'(MAX_STRUCT_LEN - 1));
    assign sts.flush_done = (flush_cnt_reg == '0);
    assign sts.out_free   = !out_valid_reg || out_ready;

    // Window shift line: shift in a byte, or rotate for the checksum scan
    always_comb
    begin
        for (int i = 0; i < MAX_STRUCT_LEN - 1; i++)
            win_next[i] = (cmd.shift || cmd.rotate) ? win_reg[i+1] : win_reg[i];
        if (cmd.shift)
            win_next[MAX_STRUCT_LEN-1] = cmd.zero_fill ? 8'd0 : in_data;
        else if (cmd.rotate)
            win_next[MAX_STRUCT_LEN-1] = win_reg[0];
        else
            win_next[MAX_STRUCT_LEN-1] = win_reg[MAX_STRUCT_LEN-1];
    end

    // Offset counters; the byte counter saturates at all ones
    always_comb
    begin
        cnt_next    = cnt_reg;
        newest_next = newest_reg;
        if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.shift)
        begin
            newest_next = cnt_reg;
            if (cnt_reg != '1)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    // Zero-fill and scan counters
    always_comb
    begin
        flush_cnt_next = flush_cnt_reg;
        if (cmd.flush_load)
            flush_cnt_next = IDX_W'(MAX_STRUCT_LEN - 1);
        else if (cmd.flush_dec)
            flush_cnt_next = flush_cnt_reg - 1'b1;

        idx_next = idx_reg;
        len_next = len_reg;
        if (cmd.scan_start)
        begin
            idx_next = '0;
            len_next = len_field[LEN_W-1:0];
        end
        else if (cmd.rotate)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Region length register
    assign region_len_next = cfg_we ? cfg_data : region_len_reg;

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_off_next   = out_off_reg;
        out_len_next   = out_len_reg;
        if (cmd.load_hit)
        begin
            out_valid_next = 1'b1;
            out_found_next = 1'b1;
            out_off_next   = head_off[OFFSET_WIDTH-1:0];
            out_len_next   = TABLE_LEN_W'(len_reg);
        end
        else if (cmd.load_miss)
        begin
            out_valid_next = 1'b1;
            out_found_next = 1'b0;
            out_off_next   = '0;
            out_len_next   = '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            newest_reg     <= '0;
            flush_cnt_reg  <= '0;
            idx_reg        <= '0;
            region_len_reg <= OFFSET_WIDTH'(REGION_LEN_RST);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            newest_reg     <= newest_next;
            flush_cnt_reg  <= flush_cnt_next;
            idx_reg        <= idx_next;
            region_len_reg <= region_len_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        sum_reg       <= sum_next;
        len_reg       <= len_next;
        out_found_reg <= out_found_next;
        out_off_reg   <= out_off_next;
        out_len_reg   <= out_len_next;
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_data  = TDATA_W'({out_len_reg, out_off_reg});

endmodule

`default_nettype wire

/* rtl/core/acpi_rsdp_signature_scanner.sv */
`default_nettype none

// Scans the bytes of one memory region, one byte per request on the s_ side,
// for the first valid ACPI root pointer ("RSD PTR " signature, nonzero
// revision, length field from 1 to MAX_STRUCT_LEN, zero checksum over that
// length) starting at an offset no greater than the region length written on
// the cfg channel. Each region, closed by s_tlast, gives exactly one result on
// the m_ side: found with offset and length, or not found after the last
// byte. While the configured region length is below MIN_REGION_LEN, every
// region reports not found. Bytes are taken at one per cycle unless a scan
// or end-of-region step holds them. A window head that passes the header
// checks holds the input while the checksum is summed by rotating the byte
// window through one adder; a found result then loads the output register.
// After the last byte the remaining candidates are checked by shifting in
// MAX_STRUCT_LEN - 1 zero bytes, one per cycle (plus the checksum scans they
// trigger); then the final window position is checked and the not-found
// result is loaded. When the result of the region was already given, a step
// after the last byte starts the next region. A result waits in the output
// register while bytes keep flowing; the block stalls only when a second
// result is due before the first is taken. The user must write configuration
// only while the block is idle; the block itself does not enforce it.

module acpi_rsdp_signature_scanner
    import rsdp_scan_pkg::*;
#(
    parameter  int MAX_STRUCT_LEN = DEF_MAX_STRUCT_LEN,
    parameter  int MIN_REGION_LEN = DEF_MIN_REGION_LEN,
    parameter  int OFFSET_WIDTH   = DEF_OFFSET_WIDTH,
    localparam int TDATA_W        = ((OFFSET_WIDTH + TABLE_LEN_W + 7) / 8) * 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Region length write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [OFFSET_WIDTH-1:0] cfg_data,
    // Byte input
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [7:0]              s_tdata,   // data_byte
    input  wire logic                    s_tlast,   // last byte of region
    // Result output
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [TDATA_W-1:0]           m_tdata,   // match_offset, table_len, zero pad
    output logic                         m_tuser    // found
);

    cmd_t    cmd;
    status_t sts;

    assign cfg_ready = 1'b1;

    rsdp_scan_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rsdp_scan_dp #(
        .MAX_STRUCT_LEN (MAX_STRUCT_LEN),
        .MIN_REGION_LEN (MIN_REGION_LEN),
        .OFFSET_WIDTH   (OFFSET_WIDTH),
        .TDATA_W        (TDATA_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_found (m_tuser)
    );

endmodule

`default_nettype wire

/* rtl/core/rsdp_scan_chk.sv */
`default_nettype none

module rsdp_scan_chk #(
    parameter int TDATA_W = 24
)
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               s_tlast,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               m_tuser
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // Not-found results carry zero offset and length
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found result with nonzero fields");

    // End of region starts the zero-fill pass, so no byte is taken next cycle
    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("byte taken right after end of region");

endmodule

bind acpi_rsdp_signature_scanner rsdp_scan_chk #(
    .TDATA_W (TDATA_W)
) u_rsdp_scan_chk (.*);

`default_nettype wire
